/* rtl/lcd4_pkg.sv */
package lcd4_pkg;

    localparam int QUEUE_DEPTH   = 2;
    localparam int STEP_W        = 6;
    localparam int INIT_STROBES  = 52;
    localparam int RAW_NIBBLES   = 4;

    localparam logic [2:0] CFG_BYTE_GAP    = 3'd2;
    localparam logic [2:0] CFG_CLEAR_EXTRA = 3'd3;
    localparam logic [2:0] CFG_POWER_ON    = 3'd4;
    localparam logic [2:0] CFG_SLOT_A      = 3'd5;
    localparam logic [2:0] CFG_SLOT_B      = 3'd6;

    localparam logic [7:0] RST_BYTE_GAP    = 8'd2;
    localparam logic [7:0] RST_CLEAR_EXTRA = 8'd5;
    localparam logic [9:0] RST_POWER_ON    = 10'd100;
    localparam logic [2:0] RST_SLOT_A      = 3'd0;
    localparam logic [2:0] RST_SLOT_B      = 3'd1;

    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF    = 8'h08;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_DISP_ON     = 8'h0C;
    localparam logic [7:0] CMD_SET_CGRAM   = 8'h40;
    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [3:0] NIB_WAKE        = 4'h3;
    localparam logic [3:0] NIB_4BIT        = 4'h2;

    localparam logic [7:0] GLYPH_A [8] = '{8'h11, 8'h12, 8'h1C, 8'h12,
                                          8'h11, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] GLYPH_B [8] = '{8'h00, 8'h04, 8'h06, 8'h1F,
                                          8'h06, 8'h04, 8'h00, 8'h00};

    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_BYTE   = 2'd1,
        REQ_CURSOR = 2'd2
    } req_type_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
    } job_t;

    typedef struct packed {
        logic [7:0] byte_gap;
        logic [7:0] clear_extra;
        logic [9:0] power_on;
        logic [2:0] slot_a;
        logic [2:0] slot_b;
    } cfg_t;

    function automatic logic [8:0] init_byte(input logic [4:0] k,
                                             input logic [2:0] slot_a,
                                             input logic [2:0] slot_b);
        logic [4:0] ia;
        logic [4:0] ib;
        logic [8:0] r;
        ia = k - 5'd6;
        ib = k - 5'd15;
        case (k)
            5'd0:    r = {1'b0, CMD_FUNC_SET};
            5'd1:    r = {1'b0, CMD_DISP_OFF};
            5'd2:    r = {1'b0, CMD_CLEAR};
            5'd3:    r = {1'b0, CMD_ENTRY_MODE};
            5'd4:    r = {1'b0, CMD_DISP_ON};
            5'd5:    r = {1'b0, CMD_SET_CGRAM | {2'b00, slot_a, 3'b000}};
            5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13:
                     r = {1'b1, GLYPH_A[ia[2:0]]};
            5'd14:   r = {1'b0, CMD_SET_CGRAM | {2'b00, slot_b, 3'b000}};
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22:
                     r = {1'b1, GLYPH_B[ib[2:0]]};
            default: r = {1'b0, CMD_SET_DDRAM};
        endcase
        return r;
    endfunction

endpackage

/* rtl/lcd4_if.sv */
interface lcd4_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic       reg_select;
    logic [3:0] column;
    logic       row;

    modport source (output valid, req_type, byte_value, reg_select, column, row,
                    input ready);
    modport sink (input valid, req_type, byte_value, reg_select, column, row,
                  output ready);
endinterface

interface lcd4_strobe_if;
    logic       valid;
    logic       ready;
    logic       rs_level;
    logic [3:0] nibble;
    logic [9:0] wait_before_ms;
    logic [8:0] wait_after_ms;
    logic       last_strobe;

    modport source (output valid, rs_level, nibble, wait_before_ms, wait_after_ms,
                    last_strobe, input ready);
    modport sink (input valid, rs_level, nibble, wait_before_ms, wait_after_ms,
                  last_strobe, output ready);
endinterface

/* rtl/char_lcd_4bit_interface_sequencer_core.sv */
// The first strobe passes the request queue, the job register and the output stage.
// Strobes then leave at one per cycle while the sink is ready: init gives 52,
// write byte and set cursor give 2; the sequencer returns to idle between requests.
// A two-entry request queue lets requests be taken while a sequence is running.
// Reset clears the queue and output stage and loads the register defaults.
module char_lcd_4bit_interface_sequencer_core #(
    parameter int QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [9:0]    cfg_data,
    lcd4_req_if.sink      req,
    lcd4_strobe_if.source strobe
);

    lcd4_pkg::cfg_t cfg_reg;
    lcd4_pkg::job_t push_job;
    lcd4_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    // writes to the enable timing registers are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte_gap    <= lcd4_pkg::RST_BYTE_GAP;
            cfg_reg.clear_extra <= lcd4_pkg::RST_CLEAR_EXTRA;
            cfg_reg.power_on    <= lcd4_pkg::RST_POWER_ON;
            cfg_reg.slot_a      <= lcd4_pkg::RST_SLOT_A;
            cfg_reg.slot_b      <= lcd4_pkg::RST_SLOT_B;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcd4_pkg::CFG_BYTE_GAP:    cfg_reg.byte_gap    <= cfg_data[7:0];
                lcd4_pkg::CFG_CLEAR_EXTRA: cfg_reg.clear_extra <= cfg_data[7:0];
                lcd4_pkg::CFG_POWER_ON:    cfg_reg.power_on    <= cfg_data;
                lcd4_pkg::CFG_SLOT_A:      cfg_reg.slot_a      <= cfg_data[2:0];
                lcd4_pkg::CFG_SLOT_B:      cfg_reg.slot_b      <= cfg_data[2:0];
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    lcd4_front u_front (
        .req      (req),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    lcd4_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .strobe (strobe)
    );

endmodule

/* rtl/lcd4_front.sv */
module lcd4_front (
    lcd4_req_if.sink     req,
    input  logic         full,
    output logic         push,
    output lcd4_pkg::job_t push_job
);

    always_comb
    begin
        req.ready         = !full;
        push              = 1'b0;
        push_job.is_init  = 1'b0;
        push_job.rs       = 1'b0;
        push_job.value    = req.byte_value;
        case (req.req_type)
            lcd4_pkg::REQ_INIT:
            begin
                push             = req.valid && !full;
                push_job.is_init = 1'b1;
            end
            lcd4_pkg::REQ_BYTE:
            begin
                push        = req.valid && !full;
                push_job.rs = req.reg_select;
            end
            lcd4_pkg::REQ_CURSOR:
            begin
                push           = req.valid && !full;
                push_job.value = {1'b1, req.row, 2'b00, req.column};
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/lcd4_queue.sv */
module lcd4_queue #(
    parameter int DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcd4_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lcd4_pkg::job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    lcd4_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/lcd4_back.sv */
module lcd4_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lcd4_pkg::cfg_t cfg,
    input  logic           empty,
    input  lcd4_pkg::job_t head,
    output logic           pop,
    lcd4_strobe_if.source  strobe
);

    localparam int STEP_W = lcd4_pkg::STEP_W;
    localparam logic [STEP_W-1:0] RAW_N  = STEP_W'(lcd4_pkg::RAW_NIBBLES);
    localparam logic [STEP_W-1:0] LAST_S = STEP_W'(lcd4_pkg::INIT_STROBES - 1);

    lcd4_pkg::back_state_t state_reg, state_next;
    lcd4_pkg::job_t        job_reg;
    logic [STEP_W-1:0]     step_reg, step_next;

    logic       ovalid_reg;
    logic       rs_reg;
    logic [3:0] nib_reg;
    logic [9:0] before_reg;
    logic [8:0] after_reg;
    logic       last_reg;

    logic       emit;
    logic       s_rs;
    logic [3:0] s_nib;
    logic [9:0] s_before;
    logic [8:0] s_after;
    logic       s_last;

    logic [STEP_W-1:0] offs;
    logic [8:0]        ib;
    logic              b_rs;
    logic [7:0]        b_val;
    logic              half;

    assign emit = (state_reg == lcd4_pkg::BK_RUN) && (!ovalid_reg || strobe.ready);

    always_comb
    begin
        offs = step_reg - RAW_N;
        ib   = lcd4_pkg::init_byte(offs[5:1], cfg.slot_a, cfg.slot_b);
        if (job_reg.is_init)
        begin
            b_rs  = ib[8];
            b_val = ib[7:0];
            half  = offs[0];
        end
        else
        begin
            b_rs  = job_reg.rs;
            b_val = job_reg.value;
            half  = step_reg[0];
        end

        s_before = '0;
        s_last   = 1'b0;
        if (job_reg.is_init && step_reg < RAW_N)
        begin
            s_rs  = 1'b0;
            s_nib = (step_reg == RAW_N - 1'b1) ? lcd4_pkg::NIB_4BIT : lcd4_pkg::NIB_WAKE;
            case (step_reg[1:0])
                2'd0:    s_after = 9'd10;
                2'd1:    s_after = 9'd5;
                default: s_after = 9'd2;
            endcase
            if (step_reg == '0)
            begin
                s_before = cfg.power_on;
            end
        end
        else
        begin
            s_rs    = b_rs;
            s_nib   = half ? b_val[3:0] : b_val[7:4];
            s_after = '0;
            if (half)
            begin
                s_after = {1'b0, cfg.byte_gap};
                if (!b_rs && b_val == lcd4_pkg::CMD_CLEAR)
                begin
                    s_after = {1'b0, cfg.byte_gap} + {1'b0, cfg.clear_extra};
                end
            end
            s_last = job_reg.is_init ? (step_reg == LAST_S) : half;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcd4_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = lcd4_pkg::BK_RUN;
                end
            end
            lcd4_pkg::BK_RUN:
            begin
                if (emit && s_last)
                begin
                    state_next = lcd4_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lcd4_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        step_next = step_reg;
        case (state_reg)
            lcd4_pkg::BK_IDLE:
            begin
                pop       = !empty;
                step_next = '0;
            end
            lcd4_pkg::BK_RUN:
            begin
                if (emit)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lcd4_pkg::BK_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (strobe.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (emit)
        begin
            rs_reg     <= s_rs;
            nib_reg    <= s_nib;
            before_reg <= s_before;
            after_reg  <= s_after;
            last_reg   <= s_last;
        end
    end

    assign strobe.valid          = ovalid_reg;
    assign strobe.rs_level       = rs_reg;
    assign strobe.nibble         = nib_reg;
    assign strobe.wait_before_ms = before_reg;
    assign strobe.wait_after_ms  = after_reg;
    assign strobe.last_strobe    = last_reg;

endmodule

/* rtl/lcd4_checker.sv */
module lcd4_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic       rs_level,
    input logic [3:0] nibble,
    input logic [9:0] wait_before_ms,
    input logic [8:0] wait_after_ms,
    input logic       last_strobe
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("strobe valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable({rs_level, nibble, wait_before_ms,
                                     wait_after_ms, last_strobe}))
        else $error("strobe payload changed while stalled");

    a_power_on_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        valid && wait_before_ms != 10'd0 |-> !rs_level && nibble == 4'h3
                                             && wait_after_ms == 9'd10)
        else $error("power-on wait on a strobe other than the first wake nibble");

    a_last_no_power_on: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_strobe |-> wait_before_ms == 10'd0)
        else $error("final strobe carries a power-on wait");

    a_data_no_power_on: assert property (@(posedge clk) disable iff (!rst_n)
        valid && rs_level |-> wait_before_ms == 10'd0)
        else $error("data strobe carries a power-on wait");

endmodule

bind char_lcd_4bit_interface_sequencer_core lcd4_checker u_lcd4_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (strobe.valid),
    .ready          (strobe.ready),
    .rs_level       (strobe.rs_level),
    .nibble         (strobe.nibble),
    .wait_before_ms (strobe.wait_before_ms),
    .wait_after_ms  (strobe.wait_after_ms),
    .last_strobe    (strobe.last_strobe)
);

/* dv/char_lcd_4bit_interface_sequencer_core_tb.sv */
module char_lcd_4bit_interface_sequencer_core_tb;
    import lcd4_pkg::*;

    localparam logic [2:0] CFG_EN_HIGH    = 3'd0;
    localparam logic [2:0] CFG_EN_LOW     = 3'd1;
    localparam logic [2:0] CFG_UNUSED     = 3'd7;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [7:0] CMD_DDRAM_ROW1 = 8'hC0;
    localparam logic [7:0] RST_EN_TIME    = 8'd2;
    localparam int NUM_REGS     = 7;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int NUM_PROBES   = 16;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic [9:0] wait_before;
        logic [8:0] wait_after;
        logic       last;
    } strobe_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       rs;
        logic [3:0] col;
        logic       row;
    } req_item_t;

    typedef struct packed {
        req_item_t  item;
        logic       typed;
        logic       exp_rs;
        logic [3:0] exp_hi;
        logic [3:0] exp_lo;
        logic [8:0] exp_gap;
    } probe_t;

    typedef logic [9:0] reg_set_t [NUM_REGS];

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [9:0] cfg_data;

    lcd4_req_if    req_bus ();
    lcd4_strobe_if strobe_bus ();

    char_lcd_4bit_interface_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .strobe    (strobe_bus)
    );

    logic [7:0] en_high_ms;
    logic [7:0] en_low_ms;
    logic [7:0] byte_gap_ms;
    logic [7:0] clear_extra_ms;
    logic [9:0] power_on_ms;
    logic [2:0] slot_a;
    logic [2:0] slot_b;

    strobe_t strobe_plan [$];
    probe_t  probes [NUM_PROBES];
    int      errors = 0;
    int      cycle_count = 0;
    bit      src_calm = 1'b0;
    bit      sink_calm = 1'b0;
    bit      long_hold_req = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report(input string msg);
        if (errors < 100)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic restore_defaults();
        en_high_ms     = RST_EN_TIME;
        en_low_ms      = RST_EN_TIME;
        byte_gap_ms    = RST_BYTE_GAP;
        clear_extra_ms = RST_CLEAR_EXTRA;
        power_on_ms    = RST_POWER_ON;
        slot_a         = RST_SLOT_A;
        slot_b         = RST_SLOT_B;
    endtask

    task automatic store_setting(input logic [2:0] idx, input logic [9:0] val);
        case (idx)
            CFG_EN_HIGH:     en_high_ms     = val[7:0];
            CFG_EN_LOW:      en_low_ms      = val[7:0];
            CFG_BYTE_GAP:    byte_gap_ms    = val[7:0];
            CFG_CLEAR_EXTRA: clear_extra_ms = val[7:0];
            CFG_POWER_ON:    power_on_ms    = val;
            CFG_SLOT_A:      slot_a         = val[2:0];
            CFG_SLOT_B:      slot_b         = val[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input reg_set_t vals, input bit poke_unused);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            store_setting(3'(i), vals[i]);
        end
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= 10'h3FF;
            @(posedge clk);
            store_setting(CFG_UNUSED, 10'h3FF);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic reg_set_t random_settings();
        reg_set_t vals;
        vals[CFG_EN_HIGH]     = 10'($urandom_range(1, 255));
        vals[CFG_EN_LOW]      = 10'($urandom_range(1, 255));
        vals[CFG_BYTE_GAP]    = 10'($urandom_range(0, 255));
        vals[CFG_CLEAR_EXTRA] = 10'($urandom_range(0, 255));
        vals[CFG_POWER_ON]    = 10'($urandom_range(0, 1023));
        vals[CFG_SLOT_A]      = 10'($urandom_range(0, 7));
        vals[CFG_SLOT_B]      = 10'($urandom_range(0, 7));
        return vals;
    endfunction

    task automatic plan_nibble(input logic rs, input logic [3:0] nib,
                               input logic [9:0] before_ms, input logic [8:0] after_ms);
        strobe_plan.push_back('{rs, nib, before_ms, after_ms, 1'b0});
    endtask

    task automatic plan_byte(input logic [7:0] b, input logic rs);
        logic [8:0] gap;
        gap = {1'b0, byte_gap_ms};
        if (!rs && b == CMD_CLEAR)
            gap = gap + {1'b0, clear_extra_ms};
        plan_nibble(rs, b[7:4], 10'd0, 9'd0);
        plan_nibble(rs, b[3:0], 10'd0, gap);
    endtask

    task automatic plan_glyph(input logic [2:0] slot, input bit second);
        plan_byte(CMD_SET_CGRAM | {2'b00, slot, 3'b000}, 1'b0);
        for (int i = 0; i < 8; i++)
            plan_byte(second ? GLYPH_B[i] : GLYPH_A[i], 1'b1);
    endtask

    task automatic plan_request(input req_item_t it);
        case (it.kind)
            REQ_INIT:
            begin
                plan_nibble(1'b0, NIB_WAKE, power_on_ms, 9'd10);
                plan_nibble(1'b0, NIB_WAKE, 10'd0, 9'd5);
                plan_nibble(1'b0, NIB_WAKE, 10'd0, 9'd2);
                plan_nibble(1'b0, NIB_4BIT, 10'd0, 9'd2);
                plan_byte(CMD_FUNC_SET, 1'b0);
                plan_byte(CMD_DISP_OFF, 1'b0);
                plan_byte(CMD_CLEAR, 1'b0);
                plan_byte(CMD_ENTRY_MODE, 1'b0);
                plan_byte(CMD_DISP_ON, 1'b0);
                plan_glyph(slot_a, 1'b0);
                plan_glyph(slot_b, 1'b1);
                plan_byte(CMD_SET_DDRAM, 1'b0);
            end
            REQ_BYTE:
                plan_byte(it.value, it.rs);
            REQ_CURSOR:
                plan_byte((it.row ? CMD_DDRAM_ROW1 : CMD_SET_DDRAM) + {4'h0, it.col}, 1'b0);
            default:
                return;
        endcase
        strobe_plan[strobe_plan.size() - 1].last = 1'b1;
    endtask

    function automatic req_item_t random_request();
        req_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.kind = REQ_INIT;
        else if (pick < 60)
            it.kind = REQ_BYTE;
        else if (pick < 93)
            it.kind = REQ_CURSOR;
        else
            it.kind = REQ_UNUSED;
        it.value = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : 8'($urandom_range(0, 255));
        it.rs    = 1'($urandom_range(0, 1));
        it.col   = 4'($urandom_range(0, 15));
        it.row   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic offer_request(input req_item_t it);
        int gap;
        gap = src_calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= it.kind;
        req_bus.byte_value <= it.value;
        req_bus.reg_select <= it.rs;
        req_bus.column     <= it.col;
        req_bus.row        <= it.row;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task automatic run_random(input int count);
        req_item_t it;
        for (int n = 0; n < count; n++)
        begin
            it = random_request();
            offer_request(it);
            plan_request(it);
        end
    endtask

    // drop valid, wait out pending strobes, then let the sequencer go idle
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (strobe_plan.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : strobe_check
        strobe_t seen;
        strobe_t want;
        if (rst_n && strobe_bus.valid && strobe_bus.ready)
        begin
            seen = '{strobe_bus.rs_level, strobe_bus.nibble, strobe_bus.wait_before_ms,
                     strobe_bus.wait_after_ms, strobe_bus.last_strobe};
            if (strobe_plan.size() == 0)
                report($sformatf("strobe transfer with nothing pending: nibble %0h",
                                 seen.nibble));
            else
            begin
                want = strobe_plan.pop_front();
                check_field("rs_level", 32'(seen.rs), 32'(want.rs));
                check_field("nibble", 32'(seen.nibble), 32'(want.nibble));
                check_field("wait_before_ms", 32'(seen.wait_before), 32'(want.wait_before));
                check_field("wait_after_ms", 32'(seen.wait_after), 32'(want.wait_after));
                check_field("last_strobe", 32'(seen.last), 32'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("char_lcd_4bit_interface_sequencer_core_tb failed");
            $finish;
        end
    end

    initial
    begin : sink_pacing
        int stall;
        strobe_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            else if (sink_calm)
                stall = 0;
            else
                stall = idle_gap();
            if (stall > 0)
            begin
                strobe_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            strobe_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        req_item_t it;
        reg_set_t  top_vals;
        reg_set_t  low_vals;
        top_vals = '{10'd255, 10'd255, 10'd255, 10'd255, 10'd1023, 10'd7, 10'd7};
        low_vals = '{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
        probes = '{
            '{'{REQ_INIT,   8'h00,     1'b0, 4'h0, 1'b0}, 1'b0, 1'b0, 4'h0, 4'h0, 9'd0},
            '{'{REQ_BYTE,   8'h00,     1'b0, 4'h0, 1'b0}, 1'b1, 1'b0, 4'h0, 4'h0, 9'd2},
            '{'{REQ_BYTE,   8'hFF,     1'b1, 4'hF, 1'b1}, 1'b1, 1'b1, 4'hF, 4'hF, 9'd2},
            '{'{REQ_BYTE,   CMD_CLEAR, 1'b0, 4'h0, 1'b0}, 1'b1, 1'b0, 4'h0, 4'h1, 9'd7},
            '{'{REQ_BYTE,   CMD_CLEAR, 1'b1, 4'h0, 1'b0}, 1'b1, 1'b1, 4'h0, 4'h1, 9'd2},
            '{'{REQ_BYTE,   8'hA5,     1'b1, 4'h0, 1'b0}, 1'b1, 1'b1, 4'hA, 4'h5, 9'd2},
            '{'{REQ_BYTE,   8'h5A,     1'b0, 4'h0, 1'b0}, 1'b1, 1'b0, 4'h5, 4'hA, 9'd2},
            '{'{REQ_CURSOR, 8'h00,     1'b0, 4'h0, 1'b0}, 1'b1, 1'b0, 4'h8, 4'h0, 9'd2},
            '{'{REQ_CURSOR, 8'hFF,     1'b1, 4'hF, 1'b1}, 1'b1, 1'b0, 4'hC, 4'hF, 9'd2},
            '{'{REQ_CURSOR, 8'h00,     1'b0, 4'hF, 1'b0}, 1'b1, 1'b0, 4'h8, 4'hF, 9'd2},
            '{'{REQ_CURSOR, 8'h00,     1'b0, 4'h0, 1'b1}, 1'b1, 1'b0, 4'hC, 4'h0, 9'd2},
            '{'{REQ_UNUSED, 8'hFF,     1'b1, 4'hF, 1'b1}, 1'b1, 1'b0, 4'h0, 4'h0, 9'd0},
            '{'{REQ_UNUSED, 8'h00,     1'b0, 4'h0, 1'b0}, 1'b1, 1'b0, 4'h0, 4'h0, 9'd0},
            '{'{REQ_BYTE,   8'h3C,     1'b1, 4'hF, 1'b1}, 1'b1, 1'b1, 4'h3, 4'hC, 9'd2},
            '{'{REQ_CURSOR, 8'hFF,     1'b1, 4'h7, 1'b0}, 1'b1, 1'b0, 4'h8, 4'h7, 9'd2},
            '{'{REQ_INIT,   8'hFF,     1'b1, 4'hF, 1'b1}, 1'b0, 1'b0, 4'h0, 4'h0, 9'd0}
        };

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_EN_HIGH;
        cfg_data           <= 10'd0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_INIT;
        req_bus.byte_value <= 8'h00;
        req_bus.reg_select <= 1'b0;
        req_bus.column     <= 4'h0;
        req_bus.row        <= 1'b0;
        restore_defaults();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_PROBES; i++)
        begin
            offer_request(probes[i].item);
            if (!probes[i].typed)
                plan_request(probes[i].item);
            else if (probes[i].item.kind != REQ_UNUSED)
            begin
                plan_nibble(probes[i].exp_rs, probes[i].exp_hi, 10'd0, 9'd0);
                plan_nibble(probes[i].exp_rs, probes[i].exp_lo, 10'd0, probes[i].exp_gap);
                strobe_plan[strobe_plan.size() - 1].last = 1'b1;
            end
        end
        settle();

        apply_config(top_vals, 1'b0);
        run_random(45);
        settle();

        apply_config(low_vals, 1'b1);
        run_random(45);
        settle();

        // stall the strobe side while init requests, then random ones, keep coming
        apply_config(random_settings(), 1'b0);
        long_hold_req = 1'b1;
        src_calm = 1'b1;
        for (int n = 0; n < 16; n++)
        begin
            it = random_request();
            if (n < 6)
                it.kind = REQ_INIT;
            offer_request(it);
            plan_request(it);
        end
        src_calm = 1'b0;
        run_random(30);
        settle();

        apply_config(random_settings(), 1'b0);
        src_calm = 1'b1;
        sink_calm = 1'b1;
        run_random(25);
        src_calm = 1'b0;
        sink_calm = 1'b0;
        run_random(20);
        settle();

        apply_config(random_settings(), 1'b0);
        run_random(45);
        settle();

        if (errors == 0)
            $display("char_lcd_4bit_interface_sequencer_core_tb passed");
        else
            $display("char_lcd_4bit_interface_sequencer_core_tb failed");
        $finish;
    end
endmodule
